// ===== rtl/core/prm_pkg.sv =====
// ----------------------------------------------------------------------------
// prm_pkg
// Shared types and constants for the FIFO/LRU page replacement block.
// ----------------------------------------------------------------------------
package prm_pkg;

  // Fixed widths of the stream fields
  localparam int PAGE_W     = 20;
  localparam int LIMIT_W    = 10;
  localparam int COUNT_W    = 32;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 88;
  localparam int CFG_IDX_W  = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_POLICY_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_LIMIT = 1'b1;

  // Policy codes
  localparam logic POLICY_FIFO = 1'b0;
  localparam logic POLICY_LRU  = 1'b1;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 10'd512;
  localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_UPDATE
  } prm_state_t;

  // Control from the sequencer to the cell row
  typedef struct packed {
    logic look;    // compare cycle
    logic update;  // shift cycle
  } prm_ctrl_t;

endpackage

// ===== rtl/core/prm_cell.sv =====
// ----------------------------------------------------------------------------
// prm_cell
// One slot of the recency stack: holds a page tag and its valid bit, compares
// against the looked-up page and takes its lower-numbered neighbor's entry on a shift.
// ----------------------------------------------------------------------------
module prm_cell #(
  parameter int TAG_W = 20
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             shift_en,
  input  logic             prev_valid,
  input  logic [TAG_W-1:0] prev_tag,
  input  logic [TAG_W-1:0] look_tag,
  output logic             valid,
  output logic [TAG_W-1:0] tag,
  output logic             match
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (shift_en) begin
      valid <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      tag <= prev_tag;
    end
  end

  assign match = valid && (tag == look_tag);

endmodule

// ===== rtl/core/prm_seq.sv =====
// ----------------------------------------------------------------------------
// prm_seq
// Transfer sequencer: accepts a reference, runs the compare and shift cycles
// and holds the shift cycle while the result register is still full.
// ----------------------------------------------------------------------------
module prm_seq (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  input  logic               out_free,
  output logic               s_tready,
  output prm_pkg::prm_ctrl_t ctrl
);

  prm_pkg::prm_state_t state, state_next;
  logic accept;

  assign accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= prm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      prm_pkg::ST_IDLE: begin
        if (accept) state_next = prm_pkg::ST_LOOK;
      end
      prm_pkg::ST_LOOK: begin
        state_next = prm_pkg::ST_UPDATE;
      end
      prm_pkg::ST_UPDATE: begin
        if (accept) state_next = prm_pkg::ST_LOOK;
        else if (out_free) state_next = prm_pkg::ST_IDLE;
      end
      default: state_next = prm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready    = 1'b0;
    ctrl.look   = 1'b0;
    ctrl.update = 1'b0;
    unique case (state)
      prm_pkg::ST_IDLE: begin
        s_tready = 1'b1;
      end
      prm_pkg::ST_LOOK: begin
        ctrl.look = 1'b1;
      end
      prm_pkg::ST_UPDATE: begin
        s_tready    = out_free;
        ctrl.update = out_free;
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/core/page_replacement_fifo_lru.sv =====
// ----------------------------------------------------------------------------
// page_replacement_fifo_lru
// Fully associative page frame set with FIFO or LRU replacement.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries one memory reference per transfer (page number).
//   Master stream returns one result per reference: hit flag, evicted page
//   and the running hit/miss totals after that reference.
//   Config port (cfg_wen/cfg_index/cfg_data) sets the policy (index 0:
//   0 = FIFO, 1 = LRU) and the active frame count (index 1); write it only
//   while no reference is in flight.
// Timing:
//   Each reference has a compare cycle, where all cells compare their tag in
//   parallel (hit position and tail page are registered), and a shift cycle,
//   where the cell row shifts by one place (not on a FIFO hit). Result shows on
//   the master side the cycle after the shift; a new reference is taken during
//   the shift cycle, so it overlaps the previous reference's shift.
// Reset: all frames empty, counters zero, LRU policy, 512 frames active.
// Stall: the result register holds until taken; the shift cycle waits for
//   it, and the slave side stops accepting meanwhile.
// ----------------------------------------------------------------------------
module page_replacement_fifo_lru #(
  parameter int FRAMES    = 512,
  parameter int PAGE_BITS = 20
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // tdata: page_number[19:0], zero [23:20]
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [prm_pkg::IN_DATA_W-1:0]         s_tdata,
  // tdata: hit[0], evicted_valid[1], evicted_page[21:2], hit_total[53:22],
  //        miss_total[85:54], zero [87:86]
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [prm_pkg::OUT_DATA_W-1:0]        m_tdata,
  input  logic                                  cfg_wen,
  input  logic [prm_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [prm_pkg::LIMIT_W-1:0]           cfg_data
);

  localparam int TAG_W = PAGE_BITS;
  localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int OCC_W = $clog2(FRAMES + 1);
  localparam int CMP_W = ((OCC_W > prm_pkg::LIMIT_W) ? OCC_W : prm_pkg::LIMIT_W) + 1;
  localparam int PW    = prm_pkg::PAGE_W;
  localparam int CW    = prm_pkg::COUNT_W;

  // Config registers
  logic                        policy_mode;
  logic [prm_pkg::LIMIT_W-1:0] frame_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      policy_mode <= prm_pkg::POLICY_LRU;
      frame_limit <= prm_pkg::LIMIT_RESET;
    end else if (cfg_wen) begin
      case (cfg_index)
        prm_pkg::REG_POLICY_MODE: policy_mode <= cfg_data[0];
        prm_pkg::REG_FRAME_LIMIT: frame_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer
  prm_pkg::prm_ctrl_t ctrl;
  logic               out_free;

  assign out_free = !m_tvalid || m_tready;

  prm_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .out_free (out_free),
    .s_tready (s_tready),
    .ctrl     (ctrl)
  );

  // Page held for the compare/shift cycles, masked to PAGE_BITS
  logic [TAG_W+PW-1:0] page_wide;
  logic [TAG_W-1:0]    look_page;

  assign page_wide = {{TAG_W{1'b0}}, s_tdata[PW-1:0]};

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      look_page <= page_wide[TAG_W-1:0];
    end
  end

  // Cell row: cell 0 is the newest entry, higher positions are older
  logic [FRAMES-1:0] cell_valid;
  logic [TAG_W-1:0]  cell_tag [FRAMES];
  logic [FRAMES-1:0] cell_match;
  logic [FRAMES-1:0] shift_en;

  logic             do_shift;
  logic [IDX_W-1:0] stop;

  genvar g;
  generate
    for (g = 0; g < FRAMES; g++) begin : g_cell
      logic             in_valid;
      logic [TAG_W-1:0] in_tag;
      if (g == 0) begin : g_head
        assign in_valid = 1'b1;
        assign in_tag   = look_page;
      end else begin : g_body
        assign in_valid = cell_valid[g-1];
        assign in_tag   = cell_tag[g-1];
      end
      assign shift_en[g] = do_shift && (IDX_W'(g) <= stop);

      prm_cell #(.TAG_W(TAG_W)) u_cell (
        .clk        (clk),
        .rst        (rst),
        .shift_en   (shift_en[g]),
        .prev_valid (in_valid),
        .prev_tag   (in_tag),
        .look_tag   (look_page),
        .valid      (cell_valid[g]),
        .tag        (cell_tag[g]),
        .match      (cell_match[g])
      );
    end
  endgenerate

  // Compare cycle: encode hit position and pick up the tail (oldest) page.
  // Resident pages are distinct, so at most one cell matches.
  logic             any_match;
  logic [IDX_W-1:0] match_idx;
  logic [TAG_W-1:0] tail_tag;
  logic             tail_flag;

  always_comb begin
    match_idx = '0;
    tail_tag  = '0;
    for (int k = 0; k < FRAMES; k++) begin
      if (cell_match[k]) match_idx = match_idx | IDX_W'(k);
      tail_flag = cell_valid[k] && ((k == FRAMES - 1) || !cell_valid[(k + 1) % FRAMES]);
      if (tail_flag) tail_tag = tail_tag | cell_tag[k];
    end
  end

  assign any_match = |cell_match;

  // Active limit: zero reads as one, anything above FRAMES as FRAMES
  logic [OCC_W-1:0] occupancy;
  logic [CMP_W-1:0] lim_raw;
  logic [CMP_W-1:0] lim_eff;
  logic             full_now;

  assign lim_raw = CMP_W'(frame_limit);

  always_comb begin
    lim_eff = lim_raw;
    if (lim_raw == '0) lim_eff = CMP_W'(1);
    if (lim_raw > CMP_W'(FRAMES)) lim_eff = CMP_W'(FRAMES);
  end

  assign full_now = CMP_W'(occupancy) >= lim_eff;

  logic             look_hit;
  logic [IDX_W-1:0] look_idx;
  logic [TAG_W-1:0] look_tail;
  logic             look_full;

  always_ff @(posedge clk) begin
    if (ctrl.look) begin
      look_hit  <= any_match;
      look_idx  <= match_idx;
      look_tail <= tail_tag;
      look_full <= full_now;
    end
  end

  // Shift cycle: cells 0..stop take their lower-numbered neighbor, cell 0 the page.
  //   LRU hit  -> stop at the hit position (page moves to the front)
  //   FIFO hit -> no shift
  //   evict    -> stop at the tail, the tail page drops out
  //   fill     -> stop one past the tail, the row grows by one
  logic [OCC_W-1:0] occ_m1;
  logic             evict;

  assign occ_m1 = occupancy - OCC_W'(1);
  assign evict  = !look_hit && look_full;

  always_comb begin
    do_shift = ctrl.update && !(look_hit && (policy_mode == prm_pkg::POLICY_FIFO));
    if (look_hit) stop = look_idx;
    else if (look_full) stop = occ_m1[IDX_W-1:0];
    else stop = occupancy[IDX_W-1:0];
  end

  // Occupancy and saturating counters
  logic [CW-1:0] hit_counter;
  logic [CW-1:0] miss_counter;
  logic [CW-1:0] hit_counter_next;
  logic [CW-1:0] miss_counter_next;

  always_comb begin
    hit_counter_next  = hit_counter;
    miss_counter_next = miss_counter;
    if (look_hit) begin
      if (hit_counter != prm_pkg::COUNT_MAX) hit_counter_next = hit_counter + CW'(1);
    end else begin
      if (miss_counter != prm_pkg::COUNT_MAX) miss_counter_next = miss_counter + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy    <= '0;
      hit_counter  <= '0;
      miss_counter <= '0;
    end else if (ctrl.update) begin
      hit_counter  <= hit_counter_next;
      miss_counter <= miss_counter_next;
      if (!look_hit && !look_full) occupancy <= occupancy + OCC_W'(1);
    end
  end

  // Result register
  logic [TAG_W+PW-1:0] tail_wide;
  logic [PW-1:0]       ev_page;

  assign tail_wide = {{PW{1'b0}}, look_tail};
  assign ev_page   = evict ? tail_wide[PW-1:0] : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctrl.update) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.update) begin
      m_tdata <= {2'b00, miss_counter_next, hit_counter_next, ev_page, evict, look_hit};
    end
  end

endmodule

// ===== dv/page_replacement_fifo_lru_tb.sv =====
// ----------------------------------------------------------------------------
// page_replacement_fifo_lru_tb
// Self-checking bench for the FIFO/LRU page frame set. A scoreboard keeps its
// own copy of the frames, their age ranks and the hit/miss totals. It predicts
// one result per reference and compares every returned transfer field by
// field. A short directed run covers the edge pages, limit zero, an oversized
// limit, a limit cut below occupancy and a policy switch mid-stream. Random
// phases with both policies and many limits follow, and both stream sides
// stall at random.
// ----------------------------------------------------------------------------
module page_replacement_fifo_lru_tb;

  localparam int N_FRAMES  = 512;
  localparam int RAND_REFS = 1950;

  // One predicted result; fields are listed in m_tdata order from the top bit down
  typedef struct packed {
    logic [prm_pkg::COUNT_W-1:0] miss_total;
    logic [prm_pkg::COUNT_W-1:0] hit_total;
    logic [prm_pkg::PAGE_W-1:0]  evicted_page;
    logic                        evicted_valid;
    logic                        hit;
  } outcome_t;

  // --------------------------------------------------------------------------
  // Scoreboard: frame set mirror plus the queue of results still owed
  // --------------------------------------------------------------------------
  class replacement_sb;
    logic [prm_pkg::PAGE_W-1:0]  tag [N_FRAMES];
    bit                          resident [N_FRAMES];
    int                          rank [N_FRAMES];   // 0 = newest / most recent
    int                          occupancy;
    logic [prm_pkg::COUNT_W-1:0] hits;
    logic [prm_pkg::COUNT_W-1:0] misses;
    logic                        policy;
    logic [prm_pkg::LIMIT_W-1:0] limit;
    outcome_t                    owed_outcomes [$];
    int                          errors;
    int                          evictions;

    function new();
      for (int j = 0; j < N_FRAMES; j++) begin
        resident[j] = 1'b0;
        rank[j]     = 0;
      end
      occupancy = 0;
      hits      = '0;
      misses    = '0;
      policy    = prm_pkg::POLICY_LRU;
      limit     = prm_pkg::LIMIT_RESET;
      errors    = 0;
      evictions = 0;
    endfunction

    function void write_reg(logic [prm_pkg::CFG_IDX_W-1:0] idx,
                            logic [prm_pkg::LIMIT_W-1:0] val);
      if (idx == prm_pkg::REG_POLICY_MODE) policy = val[0];
      else limit = val;
    endfunction

    // Frame idx becomes newest; valid frames younger than its old rank age by one
    function void promote(int idx, int old_rank);
      for (int j = 0; j < N_FRAMES; j++)
        if (j != idx && resident[j] && rank[j] < old_rank) rank[j]++;
      rank[idx] = 0;
    endfunction

    function void note_page(logic [prm_pkg::PAGE_W-1:0] page);
      outcome_t o;
      int       found;
      int       slot;
      int       oldest;
      int       lim;
      found = -1;
      slot  = -1;
      o     = '0;
      for (int j = 0; j < N_FRAMES; j++)
        if (found < 0 && resident[j] && tag[j] == page) found = j;
      if (found >= 0) begin
        o.hit = 1'b1;
        if (hits != prm_pkg::COUNT_MAX) hits++;
        // FIFO leaves the order alone on a hit
        if (policy == prm_pkg::POLICY_LRU) promote(found, rank[found]);
      end else begin
        if (misses != prm_pkg::COUNT_MAX) misses++;
        lim = (limit == 0) ? 1 : ((limit > N_FRAMES) ? N_FRAMES : int'(limit));
        if (occupancy >= lim) begin
          // full (or limit cut below occupancy): replace the highest rank
          oldest = -1;
          for (int j = 0; j < N_FRAMES; j++)
            if (resident[j] && rank[j] > oldest) begin
              oldest = rank[j];
              slot   = j;
            end
          if (slot >= 0) begin
            o.evicted_valid = 1'b1;
            o.evicted_page  = tag[slot];
            tag[slot]       = page;
            promote(slot, oldest);
            evictions++;
          end
        end
        if (!o.evicted_valid) begin
          for (int j = N_FRAMES - 1; j >= 0; j--)
            if (!resident[j]) slot = j;
          if (slot >= 0 && !resident[slot]) begin
            resident[slot] = 1'b1;
            tag[slot]      = page;
            promote(slot, occupancy);
            occupancy++;
          end
        end
      end
      o.hit_total  = hits;
      o.miss_total = misses;
      owed_outcomes.push_back(o);
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      errors++;
    endtask

    task check_result(logic [prm_pkg::OUT_DATA_W-1:0] data);
      outcome_t got;
      outcome_t want;
      got = data[$bits(outcome_t)-1:0];
      if (owed_outcomes.size() == 0) begin
        report_mismatch($sformatf("result with none owed, tdata=%h", data));
      end else begin
        want = owed_outcomes.pop_front();
        if (got.hit !== want.hit)
          report_mismatch($sformatf("hit %b, want %b", got.hit, want.hit));
        if (got.evicted_valid !== want.evicted_valid)
          report_mismatch($sformatf("evicted_valid %b, want %b",
                                    got.evicted_valid, want.evicted_valid));
        if (got.evicted_page !== want.evicted_page)
          report_mismatch($sformatf("evicted_page %h, want %h",
                                    got.evicted_page, want.evicted_page));
        if (got.hit_total !== want.hit_total)
          report_mismatch($sformatf("hit_total %0d, want %0d",
                                    got.hit_total, want.hit_total));
        if (got.miss_total !== want.miss_total)
          report_mismatch($sformatf("miss_total %0d, want %0d",
                                    got.miss_total, want.miss_total));
      end
    endtask
  endclass

  // --------------------------------------------------------------------------
  // DUT hookup
  // --------------------------------------------------------------------------
  logic                           clk       = 1'b0;
  logic                           rst       = 1'b1;
  logic                           s_tvalid  = 1'b0;
  logic                           s_tready;
  logic [prm_pkg::IN_DATA_W-1:0]  s_tdata   = '0;   // page_number[19:0], zero [23:20]
  logic                           m_tvalid;
  logic                           m_tready  = 1'b0;
  // hit[0], evicted_valid[1], evicted_page[21:2], hit_total[53:22],
  // miss_total[85:54], zero [87:86]
  logic [prm_pkg::OUT_DATA_W-1:0] m_tdata;
  logic                           cfg_wen   = 1'b0;
  logic [prm_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [prm_pkg::LIMIT_W-1:0]    cfg_data  = '0;

  replacement_sb sb;
  bit            steady = 1'b0;   // no idling on either side while set
  int            refs_sent = 0;
  int            phases = 0;

  page_replacement_fifo_lru #(
    .FRAMES   (N_FRAMES),
    .PAGE_BITS(prm_pkg::PAGE_W)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_wen  (cfg_wen),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver back-pressure: ready drops about a third of the time
  always @(posedge clk) begin
    m_tready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 32);
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // s_tvalid is left high after a transfer; a gap or drain_results lowers it
  task send_page(logic [prm_pkg::PAGE_W-1:0] page);
    if (!steady)
      while ($urandom_range(0, 99) < 32) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(prm_pkg::IN_DATA_W - prm_pkg::PAGE_W){1'b0}}, page};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_page(page);
    refs_sent++;
  endtask

  // Stop sending and wait until every owed result has come back, then let the
  // shift cycle settle before touching the config port
  task drain_results();
    s_tvalid <= 1'b0;
    while (sb.owed_outcomes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task write_reg(logic [prm_pkg::CFG_IDX_W-1:0] idx, logic [prm_pkg::LIMIT_W-1:0] val);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    sb.write_reg(idx, val);
    @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    logic [prm_pkg::PAGE_W-1:0]  pool [64];
    logic [prm_pkg::LIMIT_W-1:0] lim;
    logic [prm_pkg::PAGE_W-1:0]  page;
    logic [31:0]                 rnd;
    logic                        pol;
    int                          pool_n;
    int                          n_refs;
    int                          rand_sent;

    sb = new();
    rand_sent = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings (LRU, 512): edge pages, an LRU hit
    send_page(20'h00000);
    send_page(20'hFFFFF);
    send_page(20'h00000);
    send_page(20'hAAAAA);
    send_page(20'h55555);
    send_page(20'hFFFFF);
    send_page(20'h12345);
    drain_results();

    // Limit cut to 2 with 5 resident: each miss replaces the oldest
    write_reg(prm_pkg::REG_FRAME_LIMIT, 10'd2);
    send_page(20'h11111);
    send_page(20'h22222);
    send_page(20'h11111);
    send_page(20'h33333);
    drain_results();

    // Switch to FIFO on live ranks, limit zero acts as one frame
    write_reg(prm_pkg::REG_POLICY_MODE,
              {{(prm_pkg::LIMIT_W - 1){1'b0}}, prm_pkg::POLICY_FIFO});
    write_reg(prm_pkg::REG_FRAME_LIMIT, 10'd0);
    send_page(20'h44444);
    send_page(20'h44444);
    send_page(20'h55555);
    drain_results();

    // Oversized limit clamps to the frame count: free frames fill again
    write_reg(prm_pkg::REG_FRAME_LIMIT, 10'd1023);
    send_page(20'h66666);
    send_page(20'h77777);
    send_page(20'h66666);
    send_page(20'h88888);
    drain_results();

    // Random phases: a small page pool per phase so hits and evictions mix
    while (rand_sent < RAND_REFS) begin
      drain_results();
      if (phases == 0 || $urandom_range(0, 1)) begin
        pol = $urandom_range(0, 1) ? prm_pkg::POLICY_LRU : prm_pkg::POLICY_FIFO;
        write_reg(prm_pkg::REG_POLICY_MODE, {{(prm_pkg::LIMIT_W - 1){1'b0}}, pol});
      end
      case ($urandom_range(0, 9))
        0:       lim = 10'd0;
        1:       lim = 10'd1;
        2:       lim = 10'd2;
        3:       lim = 10'd3;
        4:       lim = 10'd8;
        5:       lim = 10'd16;
        6:       lim = 10'd512;
        7:       lim = 10'd1023;
        8:       lim = 10'($urandom_range(513, 1022));
        default: lim = 10'($urandom_range(1, 64));
      endcase
      write_reg(prm_pkg::REG_FRAME_LIMIT, lim);
      steady = (phases == 3 || phases == 4);
      pool_n = $urandom_range(1, 48);
      for (int k = 0; k < pool_n; k++) begin
        rnd     = $urandom_range(0, 20'hFFFFF);
        pool[k] = rnd[prm_pkg::PAGE_W-1:0];
      end
      n_refs = $urandom_range(40, 150);
      for (int i = 0; i < n_refs && rand_sent < RAND_REFS; i++) begin
        if ($urandom_range(0, 7) == 0) begin
          rnd  = $urandom_range(0, 20'hFFFFF);
          page = rnd[prm_pkg::PAGE_W-1:0];
        end else begin
          page = pool[$urandom_range(0, pool_n - 1)];
        end
        send_page(page);
        rand_sent++;
      end
      phases++;
    end
    steady = 1'b0;
    drain_results();
    repeat (10) @(posedge clk);

    $display("Covered %0d references over %0d random phases plus directed setup",
             refs_sent, phases);
    $display("Totals: %0d hits, %0d misses, %0d evictions, both policies",
             sb.hits, sb.misses, sb.evictions);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog: far above the slowest legal run
  initial begin
    #5000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
